// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock, off during reset
`define CPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property on the rising clock, including reset
`define CPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared widths and types of the closest pair distance block.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int CoordWidth  = 16;
  localparam int SquareWidth = 33;
  localparam int BestWidth   = 34;
  localparam int RootWidth   = 17;
  localparam int DefaultMaxPoints = 256;
  localparam int QueueDepth  = 2;

  localparam logic [BestWidth-1:0] BestReset = {BestWidth{1'b1}};

  // One point as the front part hands it to the back part
  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic                         last;
  } point_t;

endpackage

// File: sv/cpd_front.sv
// ----------------------------------------------------------------------------
// cpd_front
// Accepts points and holds them in a short queue for the search engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cpd_pkg::point_t in_point,
  output logic            q_valid,
  output cpd_pkg::point_t q_point,
  input  logic            q_pop
);

  localparam int Depth = cpd_pkg::QueueDepth;
  localparam int IdxWidth = $clog2(Depth);

  cpd_pkg::point_t        entries [Depth];
  logic [IdxWidth-1:0]    wr_ptr;
  logic [IdxWidth-1:0]    rd_ptr;
  logic [IdxWidth:0]      count;
  logic                   push;

  assign busy    = (count == (IdxWidth+1)'(Depth));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_point = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxWidth'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == IdxWidth'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (IdxWidth+1)'(push) - (IdxWidth+1)'(q_pop);
    end
  end

  `CPD_ASSERT(a_no_pop_empty, q_pop |-> q_valid, "pop from empty queue")
  `CPD_ASSERT(a_count_bound, count <= (IdxWidth+1)'(Depth), "queue count overflow")

endmodule

// File: sv/cpd_sqrt.sv
// ----------------------------------------------------------------------------
// cpd_sqrt
// Floor square root: each iterated step brings down two bits and fixes one root bit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [cpd_pkg::SquareWidth-1:0]    value,
  output logic                               done,
  output logic [cpd_pkg::RootWidth-1:0]      root
);

  localparam int VW = cpd_pkg::SquareWidth + 1;     // even width, 34
  localparam int Steps = VW / 2;
  localparam int StepW = $clog2(Steps + 1);

  logic [VW-1:0]     rem;
  logic [VW-1:0]     src;
  logic [Steps-1:0]  acc;
  logic [StepW-1:0]  steps_left;
  logic              running;
  logic [Steps+1:0]  trial;
  logic [Steps+1:0]  rem_hi;
  logic [Steps+1:0]  rem_hi_next;

  // Bring down the next two bits of the source and try root*4+1
  assign rem_hi      = {rem[Steps-1:0], src[VW-1:VW-2]};
  assign trial       = {acc, 2'b01};
  assign rem_hi_next = rem_hi - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running    <= 1'b1;
        steps_left <= StepW'(Steps);
      end else if (running) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == StepW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      src <= {1'b0, value};
      rem <= '0;
      acc <= '0;
    end else if (running) begin
      src <= {src[VW-3:0], 2'b00};
      if (rem_hi >= trial) begin
        rem <= VW'(rem_hi_next);
        acc <= {acc[Steps-2:0], 1'b1};
      end else begin
        rem <= VW'(rem_hi);
        acc <= {acc[Steps-2:0], 1'b0};
      end
    end
  end

  assign root = acc[cpd_pkg::RootWidth-1:0];

  `CPD_ASSERT(a_done_after_run, done |-> $past(running), "root done without run")

endmodule

// File: sv/cpd_back.sv
// ----------------------------------------------------------------------------
// cpd_back
// Compares each queued point with every stored point, keeps the minimum,
// stores the point while there is room and closes a set with a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_back #(
  parameter int MaxPoints = cpd_pkg::DefaultMaxPoints
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  cpd_pkg::point_t                    q_point,
  output logic                               q_pop,
  output logic [cpd_pkg::SquareWidth-1:0]    min_square,
  output logic [cpd_pkg::RootWidth-1:0]      min_distance,
  output logic                               no_pair,
  output logic                               result_valid
);

  localparam int AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CntW  = $clog2(MaxPoints + 1);
  localparam int CW    = cpd_pkg::CoordWidth;
  localparam int BW    = cpd_pkg::BestWidth;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DIFF  = 6'b000100,
    S_SQ    = 6'b001000,
    S_STORE = 6'b010000,
    S_ROOT  = 6'b100000
  } state_t;

  state_t state;

  logic [CW-1:0]           x_store [MaxPoints];
  logic [CW-1:0]           y_store [MaxPoints];
  logic [CW-1:0]           rd_x;
  logic [CW-1:0]           rd_y;
  logic [CntW-1:0]         points_held;
  logic [CntW-1:0]         idx;
  logic [BW-1:0]           best_square;
  cpd_pkg::point_t         cur;
  logic                    pending_read;   // read data valid for compare
  logic                    diff_valid;
  logic                    sq_valid;
  logic [CW:0]             dx_mag;
  logic [CW:0]             dy_mag;
  logic [2*CW+1:0]         sq_x;
  logic [2*CW+1:0]         sq_y;
  logic [BW-1:0]           sum_sq;
  logic signed [CW:0]      dx;
  logic signed [CW:0]      dy;
  logic                    store_we;
  logic                    sqrt_go;
  logic                    sqrt_done;
  logic [cpd_pkg::RootWidth-1:0] sqrt_root;

  assign store_we = (state == S_STORE) && (points_held < CntW'(MaxPoints));

  always_ff @(posedge clk) begin
    if (store_we) begin
      x_store[points_held[AddrW-1:0]] <= cur.x;
      y_store[points_held[AddrW-1:0]] <= cur.y;
    end
    rd_x <= x_store[idx[AddrW-1:0]];
    rd_y <= y_store[idx[AddrW-1:0]];
  end

  // Three-stage compare pipe: read, difference, square, then min
  assign dx = $signed({cur.x[CW-1], cur.x}) - $signed({rd_x[CW-1], rd_x});
  assign dy = $signed({cur.y[CW-1], cur.y}) - $signed({rd_y[CW-1], rd_y});
  assign sum_sq = BW'(sq_x) + BW'(sq_y);

  always_ff @(posedge clk) begin
    dx_mag <= dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    dy_mag <= dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    sq_x   <= dx_mag * dx_mag;
    sq_y   <= dy_mag * dy_mag;
  end

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign sqrt_go = (state == S_STORE) && cur.last && (points_held != '0);

  cpd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .go    (sqrt_go),
    .value (best_square[cpd_pkg::SquareWidth-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      points_held  <= '0;
      best_square  <= cpd_pkg::BestReset;
      idx          <= '0;
      pending_read <= 1'b0;
      diff_valid   <= 1'b0;
      sq_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      diff_valid   <= pending_read;
      sq_valid     <= diff_valid;
      pending_read <= 1'b0;
      if (sq_valid && sum_sq < best_square) begin
        best_square <= sum_sq;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_point;
            idx <= '0;
            state <= (points_held == '0) ? S_DIFF : S_READ;
          end
        end
        S_READ: begin
          // issue one read per cycle over the held points
          pending_read <= 1'b1;
          if (idx == points_held - 1'b1) begin
            state <= S_DIFF;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DIFF: begin
          // drain the compare pipe
          if (!pending_read && !diff_valid && !sq_valid) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_STORE;
        end
        S_STORE: begin
          if (points_held < CntW'(MaxPoints)) begin
            points_held <= points_held + 1'b1;
          end
          if (cur.last) begin
            if (points_held == '0) begin
              min_square   <= '0;
              min_distance <= '0;
              no_pair      <= 1'b1;
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end else begin
              state <= S_ROOT;
            end
            points_held <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            min_square   <= best_square[cpd_pkg::SquareWidth-1:0];
            min_distance <= sqrt_root;
            no_pair      <= 1'b0;
            result_valid <= 1'b1;
            best_square  <= cpd_pkg::BestReset;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPD_ASSERT(a_held_bound, points_held <= CntW'(MaxPoints), "store count overflow")
  `CPD_ASSERT(a_result_from_close, result_valid |-> ($past(state) == S_STORE ||
    $past(state) == S_ROOT), "result outside set close")
  `CPD_ASSERT(a_best_reset_idle, (state == S_IDLE && points_held == '0) |->
    best_square == cpd_pkg::BestReset, "minimum not cleared between sets")

endmodule

// File: sv/closest_pair_distance_top.sv
// The search takes one queued point at a time and compares it with every
// stored point before it pops another; a closing point strobes its result
// from the store state, or after the square root when points are stored.
// Two points queue ahead of the search; busy rises when the queue is full.
// Reset: synchronous rst empties the queue and the store count and clears
// the running minimum; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
// closest_pair_distance_top
// Exact closest pair search over a bounded store of 2-D points.
// ----------------------------------------------------------------------------
module closest_pair_distance_top #(
  parameter int MaxPoints = cpd_pkg::DefaultMaxPoints
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [cpd_pkg::CoordWidth-1:0]  point_x,
  input  logic signed [cpd_pkg::CoordWidth-1:0]  point_y,
  input  logic                                   last_point,
  output logic                                   result_valid,
  output logic [cpd_pkg::SquareWidth-1:0]        min_square,
  output logic [cpd_pkg::RootWidth-1:0]          min_distance,
  output logic                                   no_pair
);

  cpd_pkg::point_t in_point;
  cpd_pkg::point_t q_point;
  logic            q_valid;
  logic            q_pop;

  assign in_point = '{x: point_x, y: point_y, last: last_point};

  cpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_point (in_point),
    .q_valid  (q_valid),
    .q_point  (q_point),
    .q_pop    (q_pop)
  );

  cpd_back #(
    .MaxPoints (MaxPoints)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_point      (q_point),
    .q_pop        (q_pop),
    .min_square   (min_square),
    .min_distance (min_distance),
    .no_pair      (no_pair),
    .result_valid (result_valid)
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for closest_pair_distance_top. Points are fed through
// the start/busy handshake. A local all-pairs search predicts the minimum
// squared distance and its root. Results are checked as they are strobed out.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumPoints   = cpd_pkg::DefaultMaxPoints;
  localparam int TargetItems = 1200;
  localparam int CycleLimit  = 2000000;

  typedef struct {
    logic [cpd_pkg::SquareWidth-1:0] square;
    logic [cpd_pkg::RootWidth-1:0]   root;
    logic                            lone;
  } closest_t;

  typedef struct {
    int       x;
    int       y;
    bit       last;
    bit       typed;
    longint   square;
    int       root;
    bit       lone;
  } row_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic signed [cpd_pkg::CoordWidth-1:0] point_x = '0;
  logic signed [cpd_pkg::CoordWidth-1:0] point_y = '0;
  logic                                  last_point = 1'b0;
  logic                                  result_valid;
  logic [cpd_pkg::SquareWidth-1:0]       min_square;
  logic [cpd_pkg::RootWidth-1:0]         min_distance;
  logic                                  no_pair;

  closest_pair_distance_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .result_valid (result_valid),
    .min_square   (min_square),
    .min_distance (min_distance),
    .no_pair      (no_pair)
  );

  always #1 clk = ~clk;

  // Local copy of the point store and running minimum
  logic signed [cpd_pkg::CoordWidth-1:0] held_x [NumPoints];
  logic signed [cpd_pkg::CoordWidth-1:0] held_y [NumPoints];
  int                                    held_count = 0;
  logic [cpd_pkg::BestWidth-1:0]         best_so_far = cpd_pkg::BestReset;

  closest_t pending_results[$];
  int       errors = 0;
  int       cycles = 0;
  int       points_sent = 0;
  int       sets_closed = 0;
  int       lone_sets = 0;
  int       overfull_sets = 0;
  bit       quiet = 1'b0;

  function automatic logic [cpd_pkg::RootWidth-1:0] floor_root(longint v);
    longint r;
    longint trial;
    r = 0;
    for (int b = cpd_pkg::RootWidth - 1; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= v) r = trial;
    end
    return r[cpd_pkg::RootWidth-1:0];
  endfunction

  // Append one expected result at the tail of the queue
  task automatic expect_result(input closest_t r);
    pending_results = {pending_results, r};
  endtask

  // Fold one accepted point into the search; closes reports a finished set
  task automatic absorb_point(input logic signed [cpd_pkg::CoordWidth-1:0] px,
                              input logic signed [cpd_pkg::CoordWidth-1:0] py,
                              input logic closing, output bit closes,
                              output closest_t r);
    longint dx;
    longint dy;
    longint sq;
    int     total;
    for (int i = 0; i < held_count; i++) begin
      dx = longint'(px) - longint'(held_x[i]);
      dy = longint'(py) - longint'(held_y[i]);
      sq = dx * dx + dy * dy;
      if (sq < longint'(best_so_far)) best_so_far = sq[cpd_pkg::BestWidth-1:0];
    end
    total = held_count + 1;
    if (held_count < NumPoints) begin
      held_x[held_count] = px;
      held_y[held_count] = py;
      held_count++;
    end
    closes = closing;
    r = '{default: '0};
    if (closing) begin
      if (total < 2) begin
        r.lone = 1'b1;
      end else begin
        r.square = best_so_far[cpd_pkg::SquareWidth-1:0];
        r.root   = floor_root(longint'(best_so_far));
      end
      if (total > NumPoints) overfull_sets++;
      held_count  = 0;
      best_so_far = cpd_pkg::BestReset;
    end
  endtask

  // Present one point, hold it until accepted, then queue a result if it closes a set
  task automatic send_point(input int x, input int y, input bit last, input bit typed,
                            input closest_t typed_r);
    bit       closes;
    closest_t r;
    start      <= 1'b1;
    point_x    <= x[cpd_pkg::CoordWidth-1:0];
    point_y    <= y[cpd_pkg::CoordWidth-1:0];
    last_point <= last;
    do @(posedge clk); while (busy);
    absorb_point(x[cpd_pkg::CoordWidth-1:0], y[cpd_pkg::CoordWidth-1:0], last, closes, r);
    points_sent++;
    if (closes) begin
      sets_closed++;
      if (r.lone) lone_sets++;
      expect_result(typed ? typed_r : r);
    end
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic random_set(input int count);
    int cx;
    int cy;
    int spread;
    bit wide;
    wide   = $urandom_range(0, 2) == 0;
    cx     = $urandom_range(0, 65535) - 32768;
    cy     = $urandom_range(0, 65535) - 32768;
    spread = 1 << $urandom_range(0, 10);
    for (int i = 0; i < count; i++) begin
      int x;
      int y;
      if (wide) begin
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
      end else begin
        x = cx + $urandom_range(0, 2 * spread) - spread;
        y = cy + $urandom_range(0, 2 * spread) - spread;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
      end
      maybe_idle();
      send_point(x, y, i == count - 1, 1'b0, '{default: '0});
    end
  endtask

  row_t directed[] = '{
    '{0, 0, 1, 1, 0, 0, 1},
    '{-32768, -32768, 0, 0, 0, 0, 0},
    '{32767, 32767, 1, 1, 64'd8589672450, 92680, 0},
    '{5, 5, 0, 0, 0, 0, 0},
    '{5, 5, 1, 1, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0},
    '{256, 0, 1, 1, 65536, 256, 0},
    '{0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0},
    '{3, 0, 1, 1, 1, 1, 0},
    '{-32768, 0, 0, 0, 0, 0, 0},
    '{32767, 0, 1, 1, 64'd4294836225, 65535, 0},
    '{0, 32767, 0, 0, 0, 0, 0},
    '{0, -32768, 1, 1, 64'd4294836225, 65535, 0},
    '{-1, -1, 1, 1, 0, 0, 1},
    '{100, -200, 0, 0, 0, 0, 0},
    '{-300, 17, 0, 0, 0, 0, 0},
    '{1234, 5678, 0, 0, 0, 0, 0},
    '{-99, -211, 1, 0, 0, 0, 0},
    '{21845, -21846, 0, 0, 0, 0, 0},
    '{-21846, 21845, 1, 0, 0, 0, 0}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    closest_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result square=%0d root=%0d lone=%0b", $time,
                 min_square, min_distance, no_pair);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (min_square !== e.square) begin
          $display("%0t min_square expected %0d actual %0d", $time, e.square, min_square);
          errors++;
        end
        if (min_distance !== e.root) begin
          $display("%0t min_distance expected %0d actual %0d", $time, e.root, min_distance);
          errors++;
        end
        if (no_pair !== e.lone) begin
          $display("%0t no_pair expected %0b actual %0b", $time, e.lone, no_pair);
          errors++;
        end
      end
    end
  end

  initial begin
    closest_t typed_r;
    int       waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_r.square = directed[i].square[cpd_pkg::SquareWidth-1:0];
      typed_r.root   = directed[i].root[cpd_pkg::RootWidth-1:0];
      typed_r.lone   = directed[i].lone;
      maybe_idle();
      send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].typed, typed_r);
    end

    // Overfill the store twice so extra points are compared but not kept
    random_set(NumPoints + 3);
    random_set(NumPoints + 1 + $urandom_range(0, 6));

    while (points_sent < TargetItems) begin
      if (points_sent > TargetItems * 9 / 10) quiet = 1'b1;
      if (points_sent > TargetItems / 2 && points_sent < TargetItems / 2 + 15 &&
          pending_results.size() != 0) begin
        // Hold off until every result has drained
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      random_set($urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 12));
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 40) begin
      @(posedge clk);
      waited++;
    end

    $display("covered %0d points in %0d sets: %0d single-point, %0d past a full store",
             points_sent, sets_closed, lone_sets, overfull_sets);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
